/* rtl/radio_packet_deframer_crc_check_assert.svh */
// Assertion macros for the radio packet deframer.
// Used by the top level; no other dependencies.
`ifndef RADIO_PACKET_DEFRAMER_CRC_CHECK_ASSERT_SVH
`define RADIO_PACKET_DEFRAMER_CRC_CHECK_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Property that holds in every cycle out of reset
`define RPD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Condition in one cycle implies a condition in the next
`define RPD_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
        else $error("assertion failed");
`else
`define RPD_ASSERT(lbl, clk, rst_n, prop)
`define RPD_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt)
`endif
`endif

/* rtl/rpdcc_pkg.sv */
// Shared constants of the radio packet deframer: defaults, field sizes,
// checksum polynomials and register indexes. No dependencies.
package rpdcc_pkg;
    localparam int DEF_MAX_SPB     = 8;
    localparam int DEF_WINDOW      = 4096;
    localparam int DEF_MAX_PAYLOAD = 32;

    localparam int ADDR_MAX   = 5;
    localparam int SPAN_BITS  = 8 * (1 + ADDR_MAX + 2 + 32 + 2);
    localparam int FRAME_BITS = 8 * (ADDR_MAX + 32 + 2);

    localparam logic [7:0]  CRC8_POLY  = 8'h07;
    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [7:0]  CRC8_INIT  = 8'hff;
    localparam logic [15:0] CRC16_INIT = 16'hffff;

    // configuration register indexes
    localparam logic [2:0] REG_SPB    = 3'd0;
    localparam logic [2:0] REG_ABYTES = 3'd1;
    localparam logic [2:0] REG_DLEN   = 3'd2;
    localparam logic [2:0] REG_ALEN   = 3'd3;
    localparam logic [2:0] REG_MODE   = 3'd4;
    localparam logic [2:0] REG_FILTER = 3'd5;

    // mode flag bit positions
    localparam int MF_CTL  = 0;
    localparam int MF_DYN  = 1;
    localparam int MF_C16  = 2;
    localparam int MF_FILT = 3;

    // packet kinds
    localparam logic [1:0] KIND_DATA = 2'd0;
    localparam logic [1:0] KIND_ACK  = 2'd1;
    localparam logic [1:0] KIND_ANY  = 2'd2;
endpackage

/* rtl/radio_packet_deframer_crc_check.sv */
// Radio packet deframer with checksum test, top level.
// Depends on rpdcc_pkg and radio_packet_deframer_crc_check_assert.svh.
//
// Samples are written into a sample window memory, one per request. Once
// the window holds a maximum-length packet, each sample runs a preamble
// test of one window read per cycle through the memory's single read port.
// A passing preamble continues into a full decode at one bit per cycle,
// run again with the ack length when a data and an ack length are tried
// and the first fails, then one result per cycle on the output while it is
// not stalled. The input is stalled during a test, a decode and the results.
// Frames are compared with the previous data frame through a two-bank frame
// memory. No clearing pass is needed.
`include "radio_packet_deframer_crc_check_assert.svh"

module radio_packet_deframer_crc_check
    import rpdcc_pkg::*;
#(
    parameter int MAX_SAMPLES_PER_BIT = DEF_MAX_SPB,
    parameter int WINDOW_SAMPLES      = DEF_WINDOW,
    parameter int MAX_PAYLOAD_BYTES   = DEF_MAX_PAYLOAD
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [39:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_packet_kind,
    output logic [39:0] o_address,
    output logic [1:0]  o_packet_id,
    output logic        o_no_ack,
    output logic [5:0]  o_payload_count,
    output logic [4:0]  o_byte_index,
    output logic [7:0]  o_payload_byte,
    output logic [15:0] o_crc_value,
    output logic        o_is_retransmit,
    output logic        o_last
);
    localparam int AW   = $clog2(WINDOW_SAMPLES);
    localparam int FW   = $clog2(WINDOW_SAMPLES + 1);
    localparam int SW   = $clog2(MAX_SAMPLES_PER_BIT + 1);
    localparam int THRW = $clog2(SPAN_BITS * MAX_SAMPLES_PER_BIT + 1);
    localparam int FBW  = $clog2(FRAME_BITS);
    localparam int PIW  = (MAX_PAYLOAD_BYTES > 1) ? $clog2(MAX_PAYLOAD_BYTES) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_EVAL = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    localparam logic [2:0] PH_PRE  = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_CTL  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_CRC  = 3'd4;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW:0] b);
        logic [AW+1:0] sum;
        sum = {2'b00, a} + {1'b0, b};
        if (sum >= (AW + 2)'(WINDOW_SAMPLES)) begin
            sum = sum - (AW + 2)'(WINDOW_SAMPLES);
        end
        return sum[AW-1:0];
    endfunction

    // configuration
    logic [3:0]  r_spb;
    logic [2:0]  r_ab;
    logic [5:0]  r_dlen;
    logic [5:0]  r_alen;
    logic [3:0]  r_mode;
    logic [39:0] r_filt;

    // control
    logic [1:0]    r_state;
    logic [AW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic          r_iss_first;
    logic [AW-1:0] r_pos;
    logic          r_rd_vld;
    logic          r_rd_bit;
    logic          r_ref_pend;
    logic          r_ref;
    logic [2:0]    r_ph;
    logic [7:0]    r_cnt;
    logic          r_try_ack;
    logic          r_bank;
    logic [FBW-1:0] r_prev_bits;
    logic          r_eq;
    logic          r_cmp_vld;
    logic          r_cmp_b;
    logic          r_prev_bit;
    logic [4:0]    r_oidx;

    // decode payload registers
    logic [39:0]   r_addr;
    logic [8:0]    r_ctl;
    logic [7:0]    r_byte;
    logic [15:0]   r_crcrx;
    logic [7:0]    r_crc8;
    logic [15:0]   r_crc16;
    logic [FBW-1:0] r_nbits;
    logic [THRW-1:0] r_samp;
    logic [5:0]    r_len;
    logic          r_retx;
    logic [7:0]    r_pay [MAX_PAYLOAD_BYTES];

    // memories
    logic win_mem [WINDOW_SAMPLES];
    logic frm_mem [2 ** (FBW + 1)];

    // effective settings
    logic [SW-1:0]   s_eff;
    logic [SW-1:0]   half;
    logic [2:0]      ab_eff;
    logic [5:0]      dlen_eff;
    logic [5:0]      alen_eff;
    logic [5:0]      fixed_len;
    logic            f_ctl, f_dyn, f_c16, f_filt;
    logic            two_try;
    logic [1:0]      kind;
    logic [THRW-1:0] thr_raw;
    logic [FW-1:0]   thr;
    logic [39:0]     mask;

    always_comb begin
        if (r_spb == 4'd0) begin
            s_eff = SW'(1);
        end else if (32'(r_spb) > MAX_SAMPLES_PER_BIT) begin
            s_eff = SW'(MAX_SAMPLES_PER_BIT);
        end else begin
            s_eff = SW'(r_spb);
        end
        half = s_eff >> 1;
        if (r_ab == 3'd0) begin
            ab_eff = 3'd1;
        end else if (32'(r_ab) > ADDR_MAX) begin
            ab_eff = 3'(ADDR_MAX);
        end else begin
            ab_eff = r_ab;
        end
        dlen_eff = (32'(r_dlen) > MAX_PAYLOAD_BYTES) ? 6'(MAX_PAYLOAD_BYTES) : r_dlen;
        alen_eff = (32'(r_alen) > MAX_PAYLOAD_BYTES) ? 6'(MAX_PAYLOAD_BYTES) : r_alen;
        f_ctl  = r_mode[MF_CTL];
        f_dyn  = r_mode[MF_DYN];
        f_c16  = r_mode[MF_C16];
        f_filt = r_mode[MF_FILT];
        two_try   = !f_dyn && (dlen_eff != alen_eff);
        fixed_len = r_try_ack ? alen_eff : dlen_eff;
        kind      = two_try ? (r_try_ack ? KIND_ACK : KIND_DATA) : KIND_ANY;
        thr_raw   = THRW'(SPAN_BITS) * THRW'(s_eff);
        thr = (32'(thr_raw) > WINDOW_SAMPLES) ? FW'(WINDOW_SAMPLES) : FW'(thr_raw);
        case (ab_eff)
            3'd1:    mask = 40'h00_0000_00ff;
            3'd2:    mask = 40'h00_0000_ffff;
            3'd3:    mask = 40'h00_00ff_ffff;
            3'd4:    mask = 40'h00_ffff_ffff;
            default: mask = 40'hff_ffff_ffff;
        endcase
    end

    // sample request and window write
    logic          in_acc;
    logic          full;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] acc_head;
    logic [FW-1:0] acc_fill;
    logic          go;

    always_comb begin
        in_acc   = i_in_valid && !o_in_stall;
        full     = (32'(r_fill) >= WINDOW_SAMPLES);
        wr_addr  = full ? r_head : wrap_add(r_head, (AW + 1)'(r_fill));
        acc_head = full ? wrap_add(r_head, (AW + 1)'(1)) : r_head;
        acc_fill = full ? r_fill : r_fill + FW'(1);
        go       = in_acc && (acc_fill >= thr);
    end

    // bit consumer decisions
    logic          cons;
    logic          keep;
    logic          b;
    logic [8:0]    ctl_v;
    logic [5:0]    l6;
    logic          addr_end, ctl_end, to_len, len_bad, pay_end, crc_end;
    logic [5:0]    len_sel;
    logic [15:0]   crcrx_v;
    logic          crc_ok, pre_bad, dec_fail, restart, give_up, good, stop_now;
    logic [7:0]    crc8_n;
    logic [15:0]   crc16_n;
    logic [7:0]    byte_v;

    always_comb begin
        b        = r_rd_bit;
        cons     = (r_state == S_RUN) && r_rd_vld && !r_ref_pend;
        keep     = cons && (r_ph == PH_ADDR || r_ph == PH_CTL || r_ph == PH_PAY);
        ctl_v    = {r_ctl[7:0], b};
        l6       = (f_ctl && r_ph == PH_CTL) ? ctl_v[8:3] : 6'd0;
        addr_end = (r_ph == PH_ADDR) && (r_cnt == {2'b00, ab_eff, 3'b000} - 8'd1);
        ctl_end  = (r_ph == PH_CTL) && (r_cnt == 8'd8);
        to_len   = cons && ((addr_end && !f_ctl) || ctl_end);
        len_sel  = f_dyn ? l6 : fixed_len;
        len_bad  = f_dyn && (32'(l6) > MAX_PAYLOAD_BYTES);
        pay_end  = (r_ph == PH_PAY) && ({1'b0, r_cnt} == {r_len, 3'b000} - 9'd1);
        crc_end  = (r_ph == PH_CRC) && (r_cnt == (f_c16 ? 8'd15 : 8'd7));
        crcrx_v  = {r_crcrx[14:0], b};
        crc_ok   = f_c16 ? (crcrx_v == r_crc16) : (crcrx_v == {8'h00, r_crc8});
        pre_bad  = cons && (r_ph == PH_PRE) && (b != (r_ref ^ r_cnt[0]));
        dec_fail = (to_len && len_bad) || (cons && crc_end && !crc_ok);
        restart  = dec_fail && two_try && !r_try_ack;
        give_up  = pre_bad || (dec_fail && !restart);
        good     = cons && crc_end && crc_ok;
        stop_now = restart || give_up || good;
        crc8_n   = {r_crc8[6:0], 1'b0} ^ ((r_crc8[7] != b) ? CRC8_POLY : 8'h00);
        crc16_n  = {r_crc16[14:0], 1'b0} ^ ((r_crc16[15] != b) ? CRC16_POLY : 16'h0000);
        byte_v   = {r_byte[6:0], b};
    end

    // window skip at the end of a test or decode
    logic          skip_en;
    logic [FW-1:0] skip_n;
    logic [FW-1:0] skip_cap;
    logic          addr_match;
    logic          retx;

    always_comb begin
        skip_en = 1'b0;
        skip_n  = FW'(1);
        if (r_state == S_RUN && give_up) begin
            skip_en = 1'b1;
        end else if (r_state == S_EVAL) begin
            skip_en = 1'b1;
            skip_n  = (32'(r_samp) > 32'(r_fill)) ? r_fill : FW'(r_samp);
        end
        skip_cap   = (skip_n > r_fill) ? r_fill : skip_n;
        addr_match = (r_addr == (r_filt & mask));
        retx       = (kind == KIND_DATA) && f_ctl && (r_nbits == r_prev_bits) && r_eq;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spb  <= 4'd1;
            r_ab   <= 3'd5;
            r_dlen <= 6'd1;
            r_alen <= 6'd0;
            r_mode <= 4'd1;
            r_filt <= 40'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SPB:    r_spb  <= i_cfg_data[3:0];
                REG_ABYTES: r_ab   <= i_cfg_data[2:0];
                REG_DLEN:   r_dlen <= i_cfg_data[5:0];
                REG_ALEN:   r_alen <= i_cfg_data[5:0];
                REG_MODE:   r_mode <= i_cfg_data[3:0];
                REG_FILTER: r_filt <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sample window memory: write on request, read one position a cycle
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            win_mem[wr_addr] <= i_sample;
        end
        r_rd_bit <= win_mem[r_iss_first ? r_head : r_pos];
    end

    // frame memory: write the new bank, read the previous bank
    always_ff @(posedge i_clk) begin
        if (keep) begin
            frm_mem[{~r_bank, r_nbits}] <= b;
        end
        r_prev_bit <= frm_mem[{r_bank, r_nbits}];
    end

    // sequencer, window pointers and frame bank control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_rd_vld    <= 1'b0;
            r_iss_first <= 1'b1;
            r_ref_pend  <= 1'b1;
            r_ph        <= PH_PRE;
            r_cnt       <= 8'd0;
            r_try_ack   <= 1'b0;
            r_bank      <= 1'b0;
            r_prev_bits <= '0;
            r_eq        <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_oidx      <= 5'd0;
        end else begin
            r_rd_vld <= (r_state == S_RUN) && !stop_now;

            // advance window on request or skip
            if (in_acc) begin
                r_head <= acc_head;
                r_fill <= acc_fill;
            end else if (skip_en) begin
                r_head <= wrap_add(r_head, (AW + 1)'(skip_cap));
                r_fill <= r_fill - skip_cap;
            end

            // issue read positions
            if (r_state == S_RUN) begin
                if (r_iss_first) begin
                    r_pos       <= wrap_add(r_head, (AW + 1)'(half));
                    r_iss_first <= 1'b0;
                end else begin
                    r_pos <= wrap_add(r_pos, (AW + 1)'(s_eff));
                end
            end

            // resolve frame compare in the cycle after the bit
            r_cmp_vld <= keep;
            r_cmp_b   <= b;
            if (r_cmp_vld && (r_prev_bit != r_cmp_b)) begin
                r_eq <= 1'b0;
            end

            // consume returned bits
            if ((r_state == S_RUN) && r_rd_vld && r_ref_pend) begin
                r_ref      <= b;
                r_ref_pend <= 1'b0;
            end
            if (cons) begin
                case (r_ph)
                    PH_PRE: begin
                        if (r_cnt == 8'd7) begin
                            r_ph  <= PH_ADDR;
                            r_cnt <= 8'd0;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                    PH_ADDR: begin
                        r_addr <= {r_addr[38:0], b};
                        if (addr_end && f_ctl) begin
                            r_ph  <= PH_CTL;
                            r_cnt <= 8'd0;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                    PH_CTL: begin
                        r_ctl <= ctl_v;
                        r_cnt <= r_cnt + 8'd1;
                    end
                    PH_PAY: begin
                        r_byte <= byte_v;
                        if (r_cnt[2:0] == 3'd7) begin
                            r_pay[r_cnt[PIW+2:3]] <= byte_v;
                        end
                        if (pay_end) begin
                            r_ph  <= PH_CRC;
                            r_cnt <= 8'd0;
                        end else begin
                            r_cnt <= r_cnt + 8'd1;
                        end
                    end
                    PH_CRC: begin
                        r_crcrx <= crcrx_v;
                        r_cnt   <= r_cnt + 8'd1;
                    end
                    default: begin
                    end
                endcase
                if (r_ph != PH_PRE) begin
                    r_samp <= r_samp + THRW'(s_eff);
                end
                if (to_len) begin
                    r_len <= len_sel;
                    r_ph  <= (len_sel == 6'd0) ? PH_CRC : PH_PAY;
                    r_cnt <= 8'd0;
                end
            end
            if (keep) begin
                r_crc8  <= crc8_n;
                r_crc16 <= crc16_n;
                r_nbits <= r_nbits + FBW'(1);
            end

            // start or restart a test and decode
            if (go || (r_state == S_RUN && restart)) begin
                r_iss_first <= 1'b1;
                r_ref_pend  <= 1'b1;
                r_ph        <= PH_PRE;
                r_cnt       <= 8'd0;
                r_addr      <= 40'd0;
                r_ctl       <= 9'd0;
                r_crcrx     <= 16'd0;
                r_crc8      <= CRC8_INIT;
                r_crc16     <= CRC16_INIT;
                r_nbits     <= '0;
                r_samp      <= '0;
                r_eq        <= 1'b1;
                r_cmp_vld   <= 1'b0;
                r_try_ack   <= !go;
            end

            case (r_state)
                S_IDLE: begin
                    if (go) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (give_up) begin
                        r_state <= S_IDLE;
                    end else if (good) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_oidx <= 5'd0;
                    r_retx <= retx;
                    if (f_filt && !addr_match) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_OUT;
                        if (kind == KIND_DATA && !retx) begin
                            r_bank      <= ~r_bank;
                            r_prev_bits <= r_nbits;
                        end
                    end
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        if (o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 5'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result fields
    always_comb begin
        o_in_stall      = (r_state != S_IDLE);
        o_out_valid     = (r_state == S_OUT);
        o_packet_kind   = kind;
        o_address       = r_addr;
        o_packet_id     = r_ctl[2:1];
        o_no_ack        = r_ctl[0];
        o_payload_count = r_len;
        o_byte_index    = (r_len != 6'd0) ? r_oidx : 5'd0;
        o_payload_byte  = (r_len != 6'd0) ? r_pay[r_oidx[PIW-1:0]] : 8'd0;
        o_crc_value     = r_crcrx;
        o_is_retransmit = r_retx;
        o_last          = (r_len == 6'd0) || ({1'b0, r_oidx} == r_len - 6'd1);
    end

    `RPD_ASSERT(a_fill_bound, i_clk, i_rst_n, 32'(r_fill) <= WINDOW_SAMPLES)
    `RPD_ASSERT(a_head_bound, i_clk, i_rst_n, 32'(r_head) < WINDOW_SAMPLES)
    `RPD_ASSERT(a_out_blocks_in, i_clk, i_rst_n, !o_out_valid || o_in_stall)
    `RPD_ASSERT_NEXT(a_read_in_run, i_clk, i_rst_n, r_state != S_RUN, !r_rd_vld)
endmodule
